/* hw/rtl/itb_pkg.sv */
// itb_pkg: shared types and codes for the interval timer bank.
// Used by itb_ctrl, itb_dp and interval_timer_bank_unit; no dependencies.
package itb_pkg;

  typedef enum logic [1:0] {
    CMD_TICK   = 2'd0,
    CMD_ARM    = 2'd1,
    CMD_CANCEL = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_SCAN  = 2'd1,
    ST_DRAIN = 2'd2,
    ST_DONE  = 2'd3
  } state_t;

  // one timer slot as held in the slot memory
  typedef struct packed {
    logic [31:0] start_ms;
    logic [31:0] period;
    logic        repeat_en;
    logic        kind;
    logic [7:0]  pin;
    logic        level;
  } slot_ent_t;

  // controller to datapath commands
  typedef struct packed {
    logic arm_we;
    logic cancel_en;
    logic tick_en;
    logic scan_rd;
    logic finish;
  } dp_cmd_t;

endpackage

/* hw/rtl/interval_timer_bank_unit.sv */
// interval_timer_bank_unit: top level of the interval timer bank.
// Instantiates itb_ctrl and itb_dp; depends on itb_pkg.
//
// Usage:
//   A request is taken at a clock edge with start high and busy low. The
//   in_command code selects tick, arm or cancel; arm loads in_slot with
//   in_duration, in_repeating, in_action_kind, in_pin and in_level and starts
//   it at the current millisecond count. Arm and cancel finish in the cycle
//   they are taken; busy stays low. A slot number at or past NUM_SLOTS and
//   an unused command code are dropped.
//   A tick bumps the millisecond counter and scans the slots one per cycle
//   through the slot memory's single registered read port; busy is high
//   through the scan, drain and done states, and no request is taken until
//   it falls. Each expired slot gives one result, strobed by out_valid for
//   one cycle, in slot order; out_last marks the tick's final result, which
//   shows in the first cycle with busy low again. A tick with nothing
//   expired gives no result.
//   The receiver cannot stall: each result is taken in its strobe cycle.
//   Reset (rst_n low, synchronous) clears the counter and all active bits.
module interval_timer_bank_unit #(
  parameter int NUM_SLOTS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_command,
  input  logic [3:0]  in_slot,
  input  logic [31:0] in_duration,
  input  logic        in_repeating,
  input  logic        in_action_kind,
  input  logic [7:0]  in_pin,
  input  logic        in_level,
  output logic        out_valid,
  output logic [3:0]  out_fired_slot,
  output logic        out_fired_kind,
  output logic [7:0]  out_pin,
  output logic        out_level,
  output logic        out_last
);

  localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  itb_pkg::dp_cmd_t  cmd;
  logic [SLOT_W-1:0] scan_idx;

  itb_ctrl #(
    .NUM_SLOTS (NUM_SLOTS),
    .SLOT_W    (SLOT_W)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .in_command (in_command),
    .in_slot    (in_slot),
    .busy       (busy),
    .cmd        (cmd),
    .scan_idx   (scan_idx)
  );

  itb_dp #(
    .NUM_SLOTS (NUM_SLOTS),
    .SLOT_W    (SLOT_W)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .scan_idx       (scan_idx),
    .in_slot        (in_slot),
    .in_duration    (in_duration),
    .in_repeating   (in_repeating),
    .in_action_kind (in_action_kind),
    .in_pin         (in_pin),
    .in_level       (in_level),
    .out_valid      (out_valid),
    .out_fired_slot (out_fired_slot),
    .out_fired_kind (out_fired_kind),
    .out_pin        (out_pin),
    .out_level      (out_level),
    .out_last       (out_last)
  );

`ifndef SYNTHESIS
  // arm, cancel and unused codes never occupy the block
  a_short_req_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && (in_command != itb_pkg::CMD_TICK) |=> !busy)
    else $error("busy raised by a non-tick request");

  a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && (in_command == itb_pkg::CMD_TICK) |=> busy)
    else $error("tick request did not start a scan");

  // the final result of a tick is never followed directly by another result
  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |=> !out_valid)
    else $error("result strobed right after the last one of a tick");

  // every result other than the final one arrives while the scan is running
  a_mid_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> busy)
    else $error("non-final result outside a scan");
`endif

endmodule

/* hw/rtl/itb_ctrl.sv */
// itb_ctrl: request decode and scan sequencer for the interval timer bank.
// Depends on itb_pkg; drives itb_dp through an itb_pkg::dp_cmd_t command group.
module itb_ctrl #(
  parameter int NUM_SLOTS = 16,
  parameter int SLOT_W    = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [1:0]        in_command,
  input  logic [3:0]        in_slot,
  output logic              busy,
  output itb_pkg::dp_cmd_t  cmd,
  output logic [SLOT_W-1:0] scan_idx
);

  itb_pkg::state_t   state_r, state_nxt;
  logic [SLOT_W-1:0] idx_r, idx_nxt;
  logic              accept;
  logic              slot_ok;

  assign accept  = start && !busy;
  assign slot_ok = (32'(in_slot) < 32'(NUM_SLOTS));
  assign busy    = (state_r != itb_pkg::ST_IDLE);
  assign scan_idx = idx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= itb_pkg::ST_IDLE;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    cmd       = '0;
    unique case (state_r)
      itb_pkg::ST_IDLE: begin
        idx_nxt = '0;
        if (accept) begin
          if (in_command == itb_pkg::CMD_TICK) begin
            cmd.tick_en = 1'b1;
            state_nxt   = itb_pkg::ST_SCAN;
          end else if (in_command == itb_pkg::CMD_ARM) begin
            cmd.arm_we = slot_ok;
          end else if (in_command == itb_pkg::CMD_CANCEL) begin
            cmd.cancel_en = slot_ok;
          end
        end
      end
      itb_pkg::ST_SCAN: begin
        cmd.scan_rd = 1'b1;
        if (idx_r == SLOT_W'(NUM_SLOTS - 1)) begin
          state_nxt = itb_pkg::ST_DRAIN;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      // last slot read is evaluated here
      itb_pkg::ST_DRAIN: begin
        state_nxt = itb_pkg::ST_DONE;
      end
      itb_pkg::ST_DONE: begin
        cmd.finish = 1'b1;
        state_nxt  = itb_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = itb_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

/* hw/rtl/itb_dp.sv */
// itb_dp: slot memory, active bits, millisecond counter, expiry check and
// result registers. Depends on itb_pkg; commanded by itb_ctrl.
module itb_dp #(
  parameter int NUM_SLOTS = 16,
  parameter int SLOT_W    = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  itb_pkg::dp_cmd_t  cmd,
  input  logic [SLOT_W-1:0] scan_idx,
  input  logic [3:0]        in_slot,
  input  logic [31:0]       in_duration,
  input  logic              in_repeating,
  input  logic              in_action_kind,
  input  logic [7:0]        in_pin,
  input  logic              in_level,
  output logic              out_valid,
  output logic [3:0]        out_fired_slot,
  output logic              out_fired_kind,
  output logic [7:0]        out_pin,
  output logic              out_level,
  output logic              out_last
);

  itb_pkg::slot_ent_t slot_mem [NUM_SLOTS];
  itb_pkg::slot_ent_t rd_q_r;
  itb_pkg::slot_ent_t wr_ent;
  itb_pkg::slot_ent_t arm_ent;
  itb_pkg::slot_ent_t wb_ent;

  logic [31:0]          now_ms_r;
  logic [NUM_SLOTS-1:0] active_r, active_nxt;
  logic                 ev_v_r;
  logic [SLOT_W-1:0]    ev_idx_r;
  logic [SLOT_W-1:0]    arm_idx;
  logic [SLOT_W-1:0]    wr_addr;
  logic                 wr_en;
  logic [31:0]          elapsed;
  logic                 fire;

  // pending result: held until we know whether another slot fires this tick
  logic       pend_v_r;
  logic [3:0] pend_slot_r;
  logic       pend_kind_r;
  logic [7:0] pend_pin_r;
  logic       pend_level_r;

  assign arm_idx = SLOT_W'(in_slot);
  assign elapsed = now_ms_r - rd_q_r.start_ms;
  assign fire    = ev_v_r && active_r[ev_idx_r] && (elapsed >= rd_q_r.period);

  always_comb begin
    arm_ent.start_ms  = now_ms_r;
    arm_ent.period    = in_duration;
    arm_ent.repeat_en = in_repeating;
    arm_ent.kind      = in_action_kind;
    arm_ent.pin       = in_pin;
    arm_ent.level     = in_level;

    wb_ent          = rd_q_r;
    wb_ent.start_ms = now_ms_r;
    if (!rd_q_r.kind) begin
      wb_ent.level = ~rd_q_r.level;
    end

    wr_en   = cmd.arm_we || (fire && rd_q_r.repeat_en);
    wr_addr = cmd.arm_we ? arm_idx : ev_idx_r;
    wr_ent  = cmd.arm_we ? arm_ent : wb_ent;

    active_nxt = active_r;
    priority if (cmd.arm_we) begin
      active_nxt[arm_idx] = 1'b1;
    end else if (cmd.cancel_en) begin
      active_nxt[arm_idx] = 1'b0;
    end else if (fire && !rd_q_r.repeat_en) begin
      active_nxt[ev_idx_r] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slot_mem[wr_addr] <= wr_ent;
    end
    if (cmd.scan_rd) begin
      rd_q_r <= slot_mem[scan_idx];
    end
    ev_idx_r <= scan_idx;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      now_ms_r <= '0;
      active_r <= '0;
      ev_v_r   <= 1'b0;
    end else begin
      active_r <= active_nxt;
      ev_v_r   <= cmd.scan_rd;
      if (cmd.tick_en) begin
        now_ms_r <= now_ms_r + 32'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_v_r  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      out_valid <= 1'b0;
      if (fire) begin
        out_valid <= pend_v_r;
        pend_v_r  <= 1'b1;
      end else if (cmd.finish) begin
        out_valid <= pend_v_r;
        pend_v_r  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire || cmd.finish) begin
      out_fired_slot <= pend_slot_r;
      out_fired_kind <= pend_kind_r;
      out_pin        <= pend_pin_r;
      out_level      <= pend_level_r;
      out_last       <= cmd.finish;
    end
    if (fire) begin
      pend_slot_r  <= 4'(ev_idx_r);
      pend_kind_r  <= rd_q_r.kind;
      pend_pin_r   <= rd_q_r.kind ? 8'd0 : rd_q_r.pin;
      pend_level_r <= rd_q_r.kind ? 1'b0 : rd_q_r.level;
    end
  end

endmodule

/* bench/interval_timer_bank_unit_tb.sv */
// interval_timer_bank_unit_tb: self-checking bench for the interval timer bank.
// Drives tick/arm/cancel requests; checks expiries against a local predictor or typed rows.
// Depends on itb_pkg and interval_timer_bank_unit.
`timescale 1ns / 100ps

module interval_timer_bank_unit_tb;

  localparam int SLOT_COUNT = 16;
  localparam int LIMIT = 400000;
  localparam int TAIL_CYCLES = SLOT_COUNT + 8;
  localparam int PHASE_ITEMS = 145;
  localparam logic [1:0] CMD_TICK   = itb_pkg::CMD_TICK;
  localparam logic [1:0] CMD_ARM    = itb_pkg::CMD_ARM;
  localparam logic [1:0] CMD_CANCEL = itb_pkg::CMD_CANCEL;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [3:0]  slot;
    logic [31:0] dur;
    logic        rep;
    logic        kind;
    logic [7:0]  pin;
    logic        lvl;
  } timer_req_t;

  typedef struct packed {
    logic [3:0] fslot;
    logic       fkind;
    logic [7:0] fpin;
    logic       flevel;
    logic       flast;
  } expiry_t;

  // n_fires < 0: take expiries from the predictor, else the ones typed in
  typedef struct {
    timer_req_t req;
    int         n_fires;
    expiry_t    e0;
    expiry_t    e1;
  } stim_row_t;

  localparam expiry_t E_NONE = '0;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  in_command = 2'd0;
  logic [3:0]  in_slot = 4'd0;
  logic [31:0] in_duration = 32'd0;
  logic        in_repeating = 1'b0;
  logic        in_action_kind = 1'b0;
  logic [7:0]  in_pin = 8'd0;
  logic        in_level = 1'b0;
  logic        out_valid;
  logic [3:0]  out_fired_slot;
  logic        out_fired_kind;
  logic [7:0]  out_pin;
  logic        out_level;
  logic        out_last;

  // predicted timer state
  logic [31:0] ms_count = 32'd0;
  logic        tmr_on   [SLOT_COUNT] = '{default: 1'b0};
  logic [31:0] tmr_base [SLOT_COUNT] = '{default: 32'd0};
  logic [31:0] tmr_len  [SLOT_COUNT] = '{default: 32'd0};
  logic        tmr_rep  [SLOT_COUNT] = '{default: 1'b0};
  logic        tmr_evt  [SLOT_COUNT] = '{default: 1'b0};
  logic [7:0]  tmr_pin  [SLOT_COUNT] = '{default: 8'd0};
  logic        tmr_lvl  [SLOT_COUNT] = '{default: 1'b0};

  expiry_t     tick_fires[$];
  expiry_t     pending_fires[$];
  stim_row_t   stim_rows[$];
  int          err_count = 0;
  int          cyc = 0;
  int          burst_left = 0;

  interval_timer_bank_unit #(.NUM_SLOTS(SLOT_COUNT)) u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_command     (in_command),
    .in_slot        (in_slot),
    .in_duration    (in_duration),
    .in_repeating   (in_repeating),
    .in_action_kind (in_action_kind),
    .in_pin         (in_pin),
    .in_level       (in_level),
    .out_valid      (out_valid),
    .out_fired_slot (out_fired_slot),
    .out_fired_kind (out_fired_kind),
    .out_pin        (out_pin),
    .out_level      (out_level),
    .out_last       (out_last)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 0;
  end

  // Applies one accepted request to the predicted state; a tick leaves its
  // expiries in tick_fires, in slot order.
  function automatic void predict_fires(timer_req_t r);
    logic [31:0] elapsed;
    tick_fires.delete();
    case (r.cmd)
      CMD_ARM: begin
        tmr_on[r.slot]   = 1'b1;
        tmr_base[r.slot] = ms_count;
        tmr_len[r.slot]  = r.dur;
        tmr_rep[r.slot]  = r.rep;
        tmr_evt[r.slot]  = r.kind;
        tmr_pin[r.slot]  = r.pin;
        tmr_lvl[r.slot]  = r.lvl;
      end
      CMD_CANCEL: tmr_on[r.slot] = 1'b0;
      CMD_TICK: begin
        ms_count = ms_count + 32'd1;
        for (int k = 0; k < SLOT_COUNT; k++) begin
          elapsed = ms_count - tmr_base[k];
          if (tmr_on[k] && elapsed >= tmr_len[k]) begin
            tick_fires.push_back(expiry_t'{4'(k), tmr_evt[k],
                                           tmr_evt[k] ? 8'd0 : tmr_pin[k],
                                           tmr_evt[k] ? 1'b0 : tmr_lvl[k], 1'b0});
            if (!tmr_evt[k] && tmr_rep[k])
              tmr_lvl[k] = ~tmr_lvl[k];
            if (tmr_rep[k])
              tmr_base[k] = ms_count;
            else
              tmr_on[k] = 1'b0;
          end
        end
        if (tick_fires.size() > 0)
          tick_fires[tick_fires.size() - 1].flast = 1'b1;
      end
      default: ;
    endcase
  endfunction

  function automatic void add_row(logic [1:0] cmd, logic [3:0] slot, logic [31:0] dur,
                                  logic rep, logic kind, logic [7:0] pin, logic lvl,
                                  int n_fires, expiry_t e0, expiry_t e1);
    stim_row_t row;
    row.req     = '{cmd, slot, dur, rep, kind, pin, lvl};
    row.n_fires = n_fires;
    row.e0      = e0;
    row.e1      = e1;
    stim_rows.push_back(row);
  endfunction

  function automatic int draw_gap(int pct);
    int g;
    g = 0;
    while ($urandom_range(0, 99) < pct)
      g++;
    return g;
  endfunction

  // Mostly ticks and arms with short durations; now and then a burst that
  // arms every slot so that one tick can expire all of them.
  function automatic timer_req_t random_request();
    timer_req_t r;
    int pick;
    r.cmd  = CMD_TICK;
    r.slot = 4'($urandom_range(0, SLOT_COUNT - 1));
    r.dur  = 32'($urandom_range(0, 4));
    r.rep  = 1'($urandom);
    r.kind = 1'($urandom);
    r.pin  = 8'($urandom);
    r.lvl  = 1'($urandom);
    if (burst_left == 0 && $urandom_range(0, 99) < 2)
      burst_left = SLOT_COUNT;
    if (burst_left > 0) begin
      r.cmd  = CMD_ARM;
      r.slot = 4'(SLOT_COUNT - burst_left);
      r.dur  = 32'($urandom_range(0, 1));
      r.rep  = ($urandom_range(0, 3) == 0);
      burst_left--;
      return r;
    end
    pick = $urandom_range(0, 99);
    if (pick < 52) begin
      r.cmd = CMD_TICK;
    end else if (pick < 82) begin
      r.cmd = CMD_ARM;
      pick = $urandom_range(0, 99);
      if (pick >= 90)
        r.dur = $urandom;
      else if (pick >= 70)
        r.dur = 32'($urandom_range(5, 40));
    end else if (pick < 95) begin
      r.cmd = CMD_CANCEL;
    end else begin
      r.cmd = CMD_UNUSED;
    end
    return r;
  endfunction

  // Returns at the edge that accepts the request, with start still high.
  task automatic send_request(timer_req_t r, int n_fires, expiry_t e0, expiry_t e1,
                              int gap, bit drain);
    if (drain && pending_fires.size() != 0) begin
      start <= 1'b0;
      while (pending_fires.size() != 0)
        @(posedge clk);
    end else if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start          <= 1'b1;
    in_command     <= r.cmd;
    in_slot        <= r.slot;
    in_duration    <= r.dur;
    in_repeating   <= r.rep;
    in_action_kind <= r.kind;
    in_pin         <= r.pin;
    in_level       <= r.lvl;
    do
      @(posedge clk);
    while (busy);
    predict_fires(r);
    if (n_fires < 0) begin
      foreach (tick_fires[i])
        pending_fires.push_back(tick_fires[i]);
    end else begin
      if (n_fires > 0)
        pending_fires.push_back(e0);
      if (n_fires > 1)
        pending_fires.push_back(e1);
    end
  endtask

  function automatic void check_field(string what, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
      err_count++;
    end
  endfunction

  always @(posedge clk) begin
    expiry_t want;
    cyc <= cyc + 1;
    if (cyc >= LIMIT) begin
      $display("interval_timer_bank_unit_tb: done, errors");
      $finish;
    end else if (rst_n && out_valid) begin
      if (pending_fires.size() == 0) begin
        $display("%0t: unexpected expiry, expected none, got slot %0h", $time,
                 out_fired_slot);
        err_count++;
      end else begin
        want = pending_fires.pop_front();
        check_field("fired_slot", 8'(want.fslot), 8'(out_fired_slot));
        check_field("fired_kind", 8'(want.fkind), 8'(out_fired_kind));
        check_field("out_pin", want.fpin, out_pin);
        check_field("out_level", 8'(want.flevel), 8'(out_level));
        check_field("out_last", 8'(want.flast), 8'(out_last));
      end
    end
  end

  initial begin
    int idle_pct [3];
    int counted;
    timer_req_t r;
    idle_pct = '{18, 58, 0};

    // zero duration, repeat toggling, events, cancels, unused code,
    // longest duration, re-arm of an active slot
    add_row(CMD_TICK,   4'd0,  32'd0, 1'b0, 1'b0, 8'h00, 1'b0, 0, E_NONE, E_NONE);
    add_row(CMD_ARM,    4'd0,  32'd0, 1'b0, 1'b0, 8'hFF, 1'b1, 0, E_NONE, E_NONE);
    add_row(CMD_TICK,   4'd0,  32'd0, 1'b0, 1'b0, 8'h00, 1'b0, 1,
            '{4'd0, 1'b0, 8'hFF, 1'b1, 1'b1}, E_NONE);
    add_row(CMD_ARM,    4'd15, 32'd0, 1'b1, 1'b0, 8'h00, 1'b0, 0, E_NONE, E_NONE);
    add_row(CMD_ARM,    4'd7,  32'd1, 1'b1, 1'b1, 8'hA5, 1'b1, 0, E_NONE, E_NONE);
    add_row(CMD_TICK,   4'd0,  32'd0, 1'b0, 1'b0, 8'h00, 1'b0, 2,
            '{4'd7, 1'b1, 8'h00, 1'b0, 1'b0}, '{4'd15, 1'b0, 8'h00, 1'b0, 1'b1});
    add_row(CMD_TICK,   4'd0,  32'd0, 1'b0, 1'b0, 8'h00, 1'b0, 2,
            '{4'd7, 1'b1, 8'h00, 1'b0, 1'b0}, '{4'd15, 1'b0, 8'h00, 1'b1, 1'b1});
    add_row(CMD_CANCEL, 4'd7,  32'd0, 1'b0, 1'b0, 8'h00, 1'b0, 0, E_NONE, E_NONE);
    add_row(CMD_CANCEL, 4'd15, 32'd0, 1'b0, 1'b0, 8'h00, 1'b0, 0, E_NONE, E_NONE);
    add_row(CMD_CANCEL, 4'd3,  32'd0, 1'b0, 1'b0, 8'h00, 1'b0, 0, E_NONE, E_NONE);
    add_row(CMD_TICK,   4'd0,  32'd0, 1'b0, 1'b0, 8'h00, 1'b0, 0, E_NONE, E_NONE);
    add_row(CMD_UNUSED, 4'd5,  32'd1, 1'b1, 1'b0, 8'h3C, 1'b1, 0, E_NONE, E_NONE);
    add_row(CMD_TICK,   4'd0,  32'd0, 1'b0, 1'b0, 8'h00, 1'b0, 0, E_NONE, E_NONE);
    add_row(CMD_ARM,    4'd2,  32'hFFFF_FFFF, 1'b0, 1'b0, 8'h01, 1'b0, 0, E_NONE, E_NONE);
    add_row(CMD_TICK,   4'd0,  32'd0, 1'b0, 1'b0, 8'h00, 1'b0, -1, E_NONE, E_NONE);
    add_row(CMD_ARM,    4'd2,  32'd2, 1'b1, 1'b0, 8'h80, 1'b1, 0, E_NONE, E_NONE);
    add_row(CMD_TICK,   4'd0,  32'd0, 1'b0, 1'b0, 8'h00, 1'b0, -1, E_NONE, E_NONE);
    add_row(CMD_TICK,   4'd0,  32'd0, 1'b0, 1'b0, 8'h00, 1'b0, 1,
            '{4'd2, 1'b0, 8'h80, 1'b1, 1'b1}, E_NONE);
    add_row(CMD_TICK,   4'd0,  32'd0, 1'b0, 1'b0, 8'h00, 1'b0, -1, E_NONE, E_NONE);
    add_row(CMD_TICK,   4'd0,  32'd0, 1'b0, 1'b0, 8'h00, 1'b0, 1,
            '{4'd2, 1'b0, 8'h80, 1'b0, 1'b1}, E_NONE);
    add_row(CMD_ARM,    4'd4,  32'd3, 1'b0, 1'b1, 8'h7F, 1'b1, 0, E_NONE, E_NONE);
    add_row(CMD_CANCEL, 4'd2,  32'd0, 1'b0, 1'b0, 8'h00, 1'b0, 0, E_NONE, E_NONE);
    add_row(CMD_TICK,   4'd0,  32'd0, 1'b0, 1'b0, 8'h00, 1'b0, -1, E_NONE, E_NONE);
    add_row(CMD_TICK,   4'd0,  32'd0, 1'b0, 1'b0, 8'h00, 1'b0, -1, E_NONE, E_NONE);
    add_row(CMD_TICK,   4'd0,  32'd0, 1'b0, 1'b0, 8'h00, 1'b0, 1,
            '{4'd4, 1'b1, 8'h00, 1'b0, 1'b1}, E_NONE);

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (stim_rows[i])
      send_request(stim_rows[i].req, stim_rows[i].n_fires, stim_rows[i].e0,
                   stim_rows[i].e1, draw_gap(idle_pct[0]), 1'b0);

    for (int phase = 0; phase < 3; phase++) begin
      counted = 0;
      while (counted < PHASE_ITEMS) begin
        r = random_request();
        // hold off until all expiries are in at each phase start, and now and then
        send_request(r, -1, E_NONE, E_NONE, draw_gap(idle_pct[phase]),
                     counted == 0 || $urandom_range(0, 99) == 0);
        if (r.cmd != CMD_UNUSED)
          counted++;
      end
    end

    start <= 1'b0;
    while (pending_fires.size() != 0)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (err_count == 0)
      $display("interval_timer_bank_unit_tb: done, clean");
    else
      $display("interval_timer_bank_unit_tb: done, errors");
    $finish;
  end

endmodule
